// ----- rtl/core/phlm_pkg.sv -----
// Package for the peak-hold level meter: level width, register map,
// reset values and the Q0.32 multiply helpers.
// Depends on nothing.
package phlm_pkg;

  localparam int unsigned LEVEL_BITS = 10;
  localparam int unsigned HOLD_BITS  = 9;
  localparam int unsigned FACT_BITS  = 32;
  localparam int unsigned TICK_BITS  = 8;
  localparam int unsigned ADDR_BITS  = 4;
  localparam int unsigned DATA_BITS  = 32;

  typedef logic [LEVEL_BITS-1:0] level_t;
  typedef logic [HOLD_BITS-1:0]  hold_t;
  typedef logic [FACT_BITS-1:0]  factor_t;
  typedef logic [TICK_BITS-1:0]  ticks_t;

  // Register indexes (word address bits)
  localparam logic [1:0] REG_HOLD_TICKS  = 2'd0;
  localparam logic [1:0] REG_VALUE_START = 2'd1;
  localparam logic [1:0] REG_PEAK_START  = 2'd2;

  localparam hold_t   HOLD_MAX          = {HOLD_BITS{1'b1}};
  localparam ticks_t  HOLD_TICKS_RESET  = ticks_t'(16);
  localparam factor_t VALUE_START_RESET = factor_t'(32'd4294924346);
  localparam factor_t PEAK_START_RESET  = factor_t'(32'd4294963001);

  // Level times a Q0.32 factor, truncated
  function automatic level_t decay_level(input factor_t factor, input level_t lvl);
    logic [FACT_BITS+LEVEL_BITS-1:0] prod;
    prod = {{LEVEL_BITS{1'b0}}, factor} * {{FACT_BITS{1'b0}}, lvl};
    return prod[FACT_BITS+LEVEL_BITS-1:FACT_BITS];
  endfunction

  // Q0.32 factor squared, truncated
  function automatic factor_t square_factor(input factor_t factor);
    logic [2*FACT_BITS-1:0] prod;
    prod = {{FACT_BITS{1'b0}}, factor} * {{FACT_BITS{1'b0}}, factor};
    return prod[2*FACT_BITS-1:FACT_BITS];
  endfunction

endpackage

// ----- rtl/core/peak_hold_level_meter_unit.sv -----
// Peak-hold level meter with accelerating decay: input register, one
// pass of decay logic, result register, and the APB register file.
// Depends on phlm_pkg.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------------
//  in      | in        | in_valid_i / in_stall_o   | level_i
//  out     | out       | out_valid_o / out_stall_i | shown_level_o, peak_level_o,
//          |           |                           | changed_o
//  cfg     | in        | APB psel/penable, pready  | paddr, pwdata, prdata
//
// One level per cycle is taken while the result side does not stall; a result
// is offered once its level has passed the input and result registers.
// The decay multipliers and the peak compare sit between those two registers.
// Reset clears levels and hold count, loads the start factors and registers.
// A stalled result holds the input register, which then stalls the input.
module peak_hold_level_meter_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [phlm_pkg::LEVEL_BITS-1:0]     level_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [phlm_pkg::LEVEL_BITS-1:0]     shown_level_o,
  output logic [phlm_pkg::LEVEL_BITS-1:0]     peak_level_o,
  output logic                                changed_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [phlm_pkg::ADDR_BITS-1:0]      paddr,
  input  logic [phlm_pkg::DATA_BITS-1:0]      pwdata,
  output logic [phlm_pkg::DATA_BITS-1:0]      prdata,
  output logic                                pready
);
  import phlm_pkg::*;

  ticks_t  hold_ticks_q;
  factor_t value_start_q, peak_start_q;
  level_t  shown_q, shown_d, peak_q, peak_d;
  hold_t   hold_q, hold_d, hold_inc;
  factor_t vfact_q, vfact_d, pfact_q, pfact_d;
  logic    in_valid_q;
  level_t  level_q;
  logic    out_valid_q, changed_q, changed_d;
  level_t  out_shown_q, out_peak_q;
  logic    advance, wr_en;
  level_t  vdec, pdec;
  factor_t vsq, psq;

  // APB register file
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_ticks_q  <= HOLD_TICKS_RESET;
      value_start_q <= VALUE_START_RESET;
      peak_start_q  <= PEAK_START_RESET;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_HOLD_TICKS:  hold_ticks_q  <= pwdata[TICK_BITS-1:0];
        REG_VALUE_START: value_start_q <= pwdata;
        REG_PEAK_START:  peak_start_q  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_HOLD_TICKS:  prdata = {{(DATA_BITS-TICK_BITS){1'b0}}, hold_ticks_q};
      REG_VALUE_START: prdata = value_start_q;
      REG_PEAK_START:  prdata = peak_start_q;
      default:         prdata = '0;
    endcase
  end

  // Advance when the result register is free or being drained
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      level_q <= level_i;
    end
  end

  // Decay products, all taken from current state in parallel
  assign vdec = decay_level(vfact_q, shown_q);
  assign vsq  = square_factor(vfact_q);
  assign pdec = decay_level(pfact_q, peak_q);
  assign psq  = square_factor(pfact_q);
  assign hold_inc = (hold_q < HOLD_MAX) ? hold_q + hold_t'(1) : hold_q;

  // Next meter state
  always_comb begin
    shown_d   = shown_q;
    peak_d    = peak_q;
    hold_d    = hold_q;
    vfact_d   = vfact_q;
    pfact_d   = pfact_q;
    changed_d = 1'b0;
    if (!(level_q == '0 && peak_q == '0)) begin
      // shown level: decay on a fall, else follow the input
      if (level_q < shown_q) begin
        shown_d = vdec;
        vfact_d = vsq;
      end else begin
        shown_d = level_q;
        vfact_d = value_start_q;
      end
      // peak: take a new peak at once, else hold, then decay no lower than shown
      if (peak_q < shown_d) begin
        peak_d  = shown_d;
        hold_d  = '0;
        pfact_d = peak_start_q;
      end else begin
        hold_d = hold_inc;
        if (hold_inc > {1'b0, hold_ticks_q}) begin
          if (pdec < shown_d) begin
            peak_d = shown_d;
          end else begin
            peak_d  = pdec;
            pfact_d = psq;
          end
        end
      end
      changed_d = (shown_d != shown_q) || (peak_d != peak_q);
    end
  end

  // Meter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shown_q <= '0;
      peak_q  <= '0;
      hold_q  <= '0;
      vfact_q <= VALUE_START_RESET;
      pfact_q <= PEAK_START_RESET;
    end else if (advance) begin
      shown_q <= shown_d;
      peak_q  <= peak_d;
      hold_q  <= hold_d;
      vfact_q <= vfact_d;
      pfact_q <= pfact_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_shown_q <= shown_d;
      out_peak_q  <= peak_d;
      changed_q   <= changed_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign shown_level_o = out_shown_q;
  assign peak_level_o  = out_peak_q;
  assign changed_o     = changed_q;

endmodule

// ----- verif/testbench.sv -----
// Testbench for peak_hold_level_meter_unit. It streams levels through the meter,
// mirrors the meter in step and checks every reading field by field.
// Depends on phlm_pkg and the meter RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import phlm_pkg::*;

  // Word index past the end of the register map; writes to it are dropped
  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned DRAIN_LIMIT = 2000;

  typedef struct packed {
    level_t shown;
    level_t peak;
    logic   changed;
  } meter_reading_t;

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  level_t               level_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i;
  level_t               shown_level_o;
  level_t               peak_level_o;
  logic                 changed_o;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [DATA_BITS-1:0] pwdata = '0;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  logic        drain_stall = 1'b0;
  logic        backlog_hold = 1'b0;
  int unsigned backlog_left = 0;
  bit          idle_on = 1'b1;
  int unsigned level_count = 0;
  int unsigned mismatch_count = 0;

  // Mirror of the meter state and of its registers
  level_t  mtr_shown;
  level_t  mtr_peak;
  hold_t   mtr_hold;
  factor_t mtr_vfac;
  factor_t mtr_pfac;
  ticks_t  cfg_ticks;
  factor_t cfg_vstart;
  factor_t cfg_pstart;

  meter_reading_t pending_readings[$];

  assign out_stall_i = drain_stall | backlog_hold;

  peak_hold_level_meter_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .level_i       (level_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .shown_level_o (shown_level_o),
    .peak_level_o  (peak_level_o),
    .changed_o     (changed_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Level times a Q0.32 factor, truncated
  function automatic level_t q32_scale(input factor_t fac, input level_t lvl);
    logic [63:0] prod;
    prod = {32'd0, fac} * {{(64-LEVEL_BITS){1'b0}}, lvl};
    return level_t'(prod >> 32);
  endfunction

  // Q0.32 factor squared, truncated
  function automatic factor_t q32_square(input factor_t fac);
    logic [63:0] prod;
    prod = {32'd0, fac} * {32'd0, fac};
    return prod[63:32];
  endfunction

  // Advance the mirrored meter by one level and queue the reading it gives
  task automatic meter_predict(input level_t lvl);
    level_t         nxt_shown;
    level_t         nxt_peak;
    meter_reading_t rd;
    if (lvl == '0 && mtr_peak == '0) begin
      rd = '{mtr_shown, mtr_peak, 1'b0};
    end else begin
      if (lvl < mtr_shown) begin
        nxt_shown = q32_scale(mtr_vfac, mtr_shown);
        mtr_vfac = q32_square(mtr_vfac);
      end else begin
        nxt_shown = lvl;
        mtr_vfac = cfg_vstart;
      end
      nxt_peak = mtr_peak;
      if (nxt_peak < nxt_shown) begin
        nxt_peak = nxt_shown;
        mtr_hold = '0;
        mtr_pfac = cfg_pstart;
      end else begin
        if (mtr_hold != HOLD_MAX) mtr_hold = mtr_hold + 1'b1;
        if (mtr_hold > hold_t'(cfg_ticks)) begin
          nxt_peak = q32_scale(mtr_pfac, nxt_peak);
          if (nxt_peak < nxt_shown) begin
            nxt_peak = nxt_shown;
          end else begin
            mtr_pfac = q32_square(mtr_pfac);
          end
        end
      end
      rd = '{nxt_shown, nxt_peak, (nxt_shown != mtr_shown) || (nxt_peak != mtr_peak)};
      mtr_shown = nxt_shown;
      mtr_peak = nxt_peak;
    end
    pending_readings.push_back(rd);
  endtask

  // Offer one level after a random gap and hold it until the transfer
  task automatic send_level(input level_t lvl);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    level_i <= lvl;
    do @(posedge clk_i); while (in_stall_o);
    if (!(lvl == '0 && mtr_peak == '0)) level_count++;
    meter_predict(lvl);
  endtask

  // Drop valid and let every outstanding reading come out
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write one register over APB, then read it back
  task automatic cfg_write(input logic [1:0] idx, input logic [DATA_BITS-1:0] data);
    logic [DATA_BITS-1:0] reg_val;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_HOLD_TICKS:  cfg_ticks = data[TICK_BITS-1:0];
      REG_VALUE_START: cfg_vstart = data;
      REG_PEAK_START:  cfg_pstart = data;
      default: ;
    endcase
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    reg_val = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_HOLD_TICKS: begin
        if (reg_val[TICK_BITS-1:0] !== cfg_ticks) begin
          $error("peak_hold_ticks: expected %0d, got %0d", cfg_ticks, reg_val[TICK_BITS-1:0]);
          mismatch_count++;
        end
      end
      REG_VALUE_START: begin
        if (reg_val !== cfg_vstart) begin
          $error("value_decay_start: expected %0h, got %0h", cfg_vstart, reg_val);
          mismatch_count++;
        end
      end
      REG_PEAK_START: begin
        if (reg_val !== cfg_pstart) begin
          $error("peak_decay_start: expected %0h, got %0h", cfg_pstart, reg_val);
          mismatch_count++;
        end
      end
      default: ;
    endcase
  endtask

  task automatic cfg_all(input ticks_t ticks, input factor_t vstart, input factor_t pstart);
    wait_quiet();
    cfg_write(REG_HOLD_TICKS, {{(DATA_BITS-TICK_BITS){1'b0}}, ticks});
    cfg_write(REG_VALUE_START, vstart);
    cfg_write(REG_PEAK_START, pstart);
  endtask

  // One shaped run of levels: attack and fall, sustain and release, or noise
  task automatic send_burst();
    int unsigned kind;
    int unsigned len;
    int unsigned top;
    kind = $urandom_range(0, 9);
    len = $urandom_range(4, 30);
    top = $urandom_range(1, 1023);
    idle_on = ($urandom_range(0, 3) != 0);
    if (kind < 6) begin
      send_level(level_t'(top));
      repeat (len) begin
        send_level(($urandom_range(0, 2) == 0) ? level_t'(0) :
                   level_t'($urandom_range(0, top / 2)));
      end
    end else if (kind < 8) begin
      repeat (len) send_level(level_t'(top));
      repeat (len) send_level(level_t'(0));
    end else begin
      repeat (len) send_level(level_t'($urandom_range(0, 1023)));
    end
  endtask

  // Reset values: idle input, full scale, falls, rises, and a held peak running out
  task automatic test_directed();
    level_t seq [25];
    seq = '{10'd0, 10'd0, 10'd1023, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0,
            10'd0, 10'd1023, 10'd512, 10'd682, 10'd341, 10'd1, 10'd0, 10'd0, 10'd0,
            10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0};
    idle_on = 1'b1;
    foreach (seq[i]) send_level(seq[i]);
    // a write past the register map must leave the meter alone
    wait_quiet();
    cfg_write(REG_SPARE, '1);
    repeat (6) send_level(level_t'($urandom_range(0, 1023)));
  endtask

  // Extremes of hold time and of both start factors
  task automatic test_register_extremes();
    ticks_t  set_ticks [3];
    factor_t set_vstart [3];
    factor_t set_pstart [3];
    set_ticks = '{8'd0, 8'd255, 8'd1};
    set_vstart = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000};
    set_pstart = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_0000};
    foreach (set_ticks[i]) begin
      cfg_all(set_ticks[i], set_vstart[i], set_pstart[i]);
      send_level(10'd1023);
      repeat (12) send_level(level_t'($urandom_range(0, 200)));
      repeat (6) send_level(10'd0);
    end
  endtask

  // Hold a steady level long enough to fill the hold counter, then drop
  task automatic test_hold_saturation();
    cfg_all(8'd255, VALUE_START_RESET, PEAK_START_RESET);
    idle_on = 1'b0;
    repeat (520) send_level(10'd600);
    repeat (6) send_level(10'd100);
    idle_on = 1'b1;
  endtask

  // Hold the result side off so the meter fills and stalls its input
  task automatic test_backpressure();
    wait_quiet();
    idle_on = 1'b0;
    backlog_left = 120;
    repeat (40) send_level(level_t'($urandom_range(0, 1023)));
    idle_on = 1'b1;
  endtask

  // Shaped random traffic over several register settings
  task automatic test_random_traffic();
    int unsigned ph;
    int unsigned target;
    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: cfg_all(ticks_t'($urandom_range(0, 255)), $urandom | 32'hFF00_0000,
                   $urandom | 32'hFFF0_0000);
        1: cfg_all(8'd0, $urandom, $urandom);
        2: cfg_all(ticks_t'($urandom_range(0, 8)), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        3: cfg_all(ticks_t'($urandom_range(0, 255)), $urandom | 32'h8000_0000, 32'd0);
        default: cfg_all(HOLD_TICKS_RESET, VALUE_START_RESET, PEAK_START_RESET);
      endcase
      target = level_count + 12;
      while (level_count < target) send_burst();
    end
    idle_on = 1'b1;
  endtask

  // Pace the result side: a random stall before each transfer
  initial begin : drain_pacing
    int unsigned hold_cycles;
    forever begin
      hold_cycles = idle_on ? $urandom_range(0, 7) : 0;
      if (hold_cycles != 0) begin
        drain_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk_i);
      end
      drain_stall <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  // Count down a long hold-off on the result side
  always @(posedge clk_i) begin
    if (backlog_left != 0) begin
      backlog_hold <= 1'b1;
      backlog_left--;
    end else begin
      backlog_hold <= 1'b0;
    end
  end

  // Compare each reading with the oldest one predicted
  always @(posedge clk_i) begin : reading_check
    meter_reading_t exp_rd;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_readings.size() == 0) begin
        $error("unexpected reading: shown_level %0d peak_level %0d changed %0b",
               shown_level_o, peak_level_o, changed_o);
        mismatch_count++;
      end else begin
        exp_rd = pending_readings.pop_front();
        if (shown_level_o !== exp_rd.shown) begin
          $error("shown_level: expected %0d, got %0d", exp_rd.shown, shown_level_o);
          mismatch_count++;
        end
        if (peak_level_o !== exp_rd.peak) begin
          $error("peak_level: expected %0d, got %0d", exp_rd.peak, peak_level_o);
          mismatch_count++;
        end
        if (changed_o !== exp_rd.changed) begin
          $error("changed: expected %0b, got %0b", exp_rd.changed, changed_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int unsigned waited;
    mtr_shown = '0;
    mtr_peak = '0;
    mtr_hold = '0;
    cfg_ticks = HOLD_TICKS_RESET;
    cfg_vstart = VALUE_START_RESET;
    cfg_pstart = PEAK_START_RESET;
    mtr_vfac = VALUE_START_RESET;
    mtr_pfac = PEAK_START_RESET;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_register_extremes();
    test_hold_saturation();
    test_backpressure();
    test_random_traffic();

    // drain what is still in flight, within a bound
    in_valid_i <= 1'b0;
    waited = 0;
    while (pending_readings.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_readings.size() != 0) begin
      $error("%0d readings never arrived", pending_readings.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("peak_hold_level_meter_unit test passed");
    end else begin
      $display("peak_hold_level_meter_unit test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("peak_hold_level_meter_unit test failed");
    $finish;
  end

endmodule
